@@ sv/i2cm_pkg.sv @@
// ---------------------------------------------------------------------------
// i2cm_pkg
// shared types and constants for the i2c master transfer engine
// ---------------------------------------------------------------------------
package i2cm_pkg;

	localparam int LENGTH_BITS_DEF  = 16;
	localparam int DIVIDER_BITS_DEF = 12;

	localparam logic [1:0] MODE_TICK  = 2'd0;
	localparam logic [1:0] MODE_MSG   = 2'd1;
	localparam logic [1:0] MODE_WBYTE = 2'd2;

	localparam logic [2:0] CFG_DIV  = 3'd0;
	localparam logic [2:0] CFG_FAST = 3'd1;
	localparam logic [2:0] CFG_ADDR = 3'd2;
	localparam logic [2:0] CFG_TEN  = 3'd3;
	localparam logic [2:0] CFG_TMO  = 3'd4;

	localparam logic [2:0] ST_OK   = 3'd0;
	localparam logic [2:0] ST_NACK = 3'd1;
	localparam logic [2:0] ST_ARB  = 3'd2;
	localparam logic [2:0] ST_BUS  = 3'd3;
	localparam logic [2:0] ST_TMO  = 3'd4;

	localparam logic [3:0] P_IDLE        = 4'd0;
	localparam logic [3:0] P_BUSFREE     = 4'd1;
	localparam logic [3:0] P_RS_LOW      = 4'd2;
	localparam logic [3:0] P_RS_RISE     = 4'd3;
	localparam logic [3:0] P_START_SETUP = 4'd4;
	localparam logic [3:0] P_START_HOLD  = 4'd5;
	localparam logic [3:0] P_BIT_LOW     = 4'd6;
	localparam logic [3:0] P_BIT_RISE    = 4'd7;
	localparam logic [3:0] P_BIT_HIGH    = 4'd8;
	localparam logic [3:0] P_WAIT_BYTE   = 4'd9;
	localparam logic [3:0] P_STOP_LOW    = 4'd10;
	localparam logic [3:0] P_STOP_RISE   = 4'd11;
	localparam logic [3:0] P_STOP_HIGH   = 4'd12;
	localparam logic [3:0] P_STOP_FREE   = 4'd13;

	localparam logic [7:0] HDR_BASE = 8'hF0;

	localparam int IN_W  = 32;
	localparam int OUT_W = 16;

	typedef struct packed {
		logic [1:0]  mode;
		logic        msg_read;
		logic        msg_start;
		logic        msg_stop;
		logic [15:0] msg_length;
		logic [7:0]  write_byte;
		logic        sda_in;
		logic        scl_in;
	} tick_t;

	typedef struct packed {
		logic       scl_low;
		logic       sda_low;
		logic [7:0] read_byte;
		logic       read_valid;
		logic       need_write_byte;
		logic       message_done;
		logic [2:0] status;
		logic       busy_res;
	} res_t;

	typedef struct packed {
		logic [15:0] timeout_ticks;
		logic        ten_bit_address;
		logic [9:0]  target_address;
		logic        fast_mode;
	} cfg_t;

endpackage

@@ sv/i2cm_cfg_regs.sv @@
// ---------------------------------------------------------------------------
// i2cm_cfg_regs
// configuration register file, written through a plain write port
// ---------------------------------------------------------------------------
module i2cm_cfg_regs #(
	parameter int DIVIDER_BITS = i2cm_pkg::DIVIDER_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [2:0]              cfg_index,
	input  logic [15:0]             cfg_data,
	output logic [DIVIDER_BITS-1:0] divider,
	output i2cm_pkg::cfg_t          cfg
);
	import i2cm_pkg::*;

	logic [DIVIDER_BITS-1:0] div_q;
	cfg_t                    cfg_q;
	logic [11:0]             div_in;

	assign div_in = cfg_data[11:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_q <= DIVIDER_BITS'(80);
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DIV:  div_q <= DIVIDER_BITS'(div_in);
				CFG_FAST: cfg_q.fast_mode <= cfg_data[0];
				CFG_ADDR: cfg_q.target_address <= cfg_data[9:0];
				CFG_TEN:  cfg_q.ten_bit_address <= cfg_data[0];
				CFG_TMO:  cfg_q.timeout_ticks <= cfg_data;
				default: ;
			endcase
		end
	end

	assign divider = div_q;
	assign cfg     = cfg_q;
endmodule

@@ sv/i2cm_engine.sv @@
// ---------------------------------------------------------------------------
// i2cm_engine
// per-tick bus state machine: state registers, next-state logic, combinational result
// ---------------------------------------------------------------------------
module i2cm_engine #(
	parameter int LENGTH_BITS  = i2cm_pkg::LENGTH_BITS_DEF,
	parameter int DIVIDER_BITS = i2cm_pkg::DIVIDER_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    step,
	input  i2cm_pkg::tick_t         tick,
	input  logic [DIVIDER_BITS-1:0] divider,
	input  i2cm_pkg::cfg_t          cfg,
	output i2cm_pkg::res_t          res
);
	import i2cm_pkg::*;

	localparam int CW = DIVIDER_BITS + 1;

	logic [3:0]             phase_q, phase_d;
	logic [3:0]             bitc_q, bitc_d;
	logic [7:0]             shb_q, shb_d;
	logic [LENGTH_BITS-1:0] left_q, left_d;
	logic [CW-1:0]          dcnt_q, dcnt_d;
	logic [15:0]            wcnt_q, wcnt_d;
	logic                   dir_q, dir_d, stopw_q, stopw_d, own_q, own_d;
	logic [1:0]             astep_q, astep_d;
	logic                   seen_q, seen_d;
	logic [2:0]             err_q, err_d;
	logic                   scl_q, scl_d, sda_q, sda_d;

	logic [CW-1:0]          hi_t, lo_t, dinc;
	logic [DIVIDER_BITS-1:0] dv;
	logic                   recv, hi_hit, lo_hit, tmo;
	logic [15:0]            winc;
	logic [7:0]             hdr, rb;
	logic                   rv, done;
	logic [2:0]             st;
	logic [LENGTH_BITS-1:0] len, left_dec;

	always_comb begin
		dv   = (divider == '0) ? DIVIDER_BITS'(1) : divider;
		hi_t = CW'(dv);
		lo_t = cfg.fast_mode ? {dv, 1'b0} : CW'(dv);
		if (lo_t < CW'(2)) lo_t = CW'(2);
		dinc   = dcnt_q + CW'(1);
		hi_hit = dinc >= hi_t;
		lo_hit = dinc >= lo_t;
		winc   = (wcnt_q == 16'hFFFF) ? wcnt_q : wcnt_q + 16'd1;
		tmo    = (cfg.timeout_ticks != '0) && (winc >= cfg.timeout_ticks);
		recv   = (astep_q == 2'd0) && dir_q;
		hdr    = HDR_BASE | {5'd0, cfg.target_address[9:8], 1'b0};
		len    = LENGTH_BITS'(tick.msg_length);
		left_dec = (left_q != '0) ? left_q - LENGTH_BITS'(1) : left_q;
	end

	always_comb begin
		phase_d = phase_q; bitc_d = bitc_q; shb_d = shb_q; left_d = left_q;
		dcnt_d = dcnt_q; wcnt_d = wcnt_q; dir_d = dir_q; stopw_d = stopw_q;
		own_d = own_q; astep_d = astep_q; seen_d = seen_q; err_d = err_q;
		scl_d = scl_q; sda_d = sda_q;
		rb = '0; rv = 1'b0; done = 1'b0; st = ST_OK;
		unique case (phase_q)
			P_IDLE: begin
				if (own_q) sda_d = 1'b0;
				if (tick.mode == MODE_MSG) begin
					if (len == '0) begin
						done = 1'b1; st = ST_BUS;
					end else begin
						dir_d = tick.msg_read; stopw_d = tick.msg_stop; left_d = len;
						err_d = ST_OK; dcnt_d = '0; wcnt_d = '0;
						if (tick.msg_start) begin
							astep_d = 2'd0;
							phase_d = own_q ? P_RS_LOW : P_BUSFREE;
						end else if (!own_q) begin
							done = 1'b1; st = ST_BUS;
						end else begin
							astep_d = 2'd0; bitc_d = '0;
							phase_d = tick.msg_read ? P_BIT_LOW : P_WAIT_BYTE;
						end
					end
				end
			end
			P_BUSFREE: begin
				if (tick.scl_in && tick.sda_in) begin
					dcnt_d = '0; phase_d = P_START_SETUP;
				end else begin
					wcnt_d = winc;
					if (tmo) begin phase_d = P_IDLE; done = 1'b1; st = ST_TMO; end
				end
			end
			P_RS_LOW: begin
				scl_d = 1'b1; sda_d = 1'b0;
				dcnt_d = lo_hit ? '0 : dinc;
				if (lo_hit) begin scl_d = 1'b0; wcnt_d = '0; phase_d = P_RS_RISE; end
			end
			P_START_SETUP: begin
				if (!tick.sda_in) begin
					scl_d = 1'b0; sda_d = 1'b0; own_d = 1'b0;
					phase_d = P_IDLE; done = 1'b1; st = ST_ARB;
				end else begin
					dcnt_d = hi_hit ? '0 : dinc;
					if (hi_hit) begin sda_d = 1'b1; phase_d = P_START_HOLD; end
				end
			end
			P_START_HOLD: begin
				dcnt_d = hi_hit ? '0 : dinc;
				if (hi_hit) begin
					scl_d = 1'b1; own_d = 1'b1; bitc_d = '0; phase_d = P_BIT_LOW;
					if (astep_q == 2'd2) begin
						astep_d = 2'd3; shb_d = hdr | 8'h01;
					end else begin
						astep_d = 2'd1;
						shb_d = cfg.ten_bit_address ? hdr
						      : {cfg.target_address[6:0], dir_q};
					end
				end
			end
			P_BIT_LOW: begin
				if (dcnt_q == '0) begin
					if (bitc_q < 4'd8)
						sda_d = recv ? 1'b0 : ~shb_q[3'(4'd7 - bitc_q)];
					else
						sda_d = recv && (left_q > LENGTH_BITS'(1));
				end
				dcnt_d = lo_hit ? '0 : dinc;
				if (lo_hit) begin scl_d = 1'b0; wcnt_d = '0; phase_d = P_BIT_RISE; end
			end
			P_BIT_HIGH: begin
				if (tick.sda_in != seen_q) begin
					err_d = ST_BUS; scl_d = 1'b1; dcnt_d = '0; phase_d = P_STOP_LOW;
				end else begin
					dcnt_d = hi_hit ? '0 : dinc;
					if (hi_hit) begin
						scl_d = 1'b1;
						if (bitc_q < 4'd8) begin
							if (recv && bitc_q == 4'd7) begin rb = shb_q; rv = 1'b1; end
							bitc_d = bitc_q + 4'd1; phase_d = P_BIT_LOW;
						end else begin
							bitc_d = '0; dcnt_d = '0; wcnt_d = '0;
							if (recv) begin
								left_d = left_dec;
								if (left_dec == '0) begin
									if (stopw_q) begin err_d = ST_OK; phase_d = P_STOP_LOW; end
									else begin phase_d = P_IDLE; done = 1'b1; end
								end else phase_d = P_BIT_LOW;
							end else if (seen_q) begin
								err_d = ST_NACK; phase_d = P_STOP_LOW;
							end else if (astep_q == 2'd1 && cfg.ten_bit_address) begin
								shb_d = cfg.target_address[7:0]; astep_d = 2'd2;
								phase_d = P_BIT_LOW;
							end else if (astep_q == 2'd2 && dir_q) begin
								phase_d = P_RS_LOW;
							end else if (astep_q != 2'd0) begin
								astep_d = 2'd0;
								phase_d = dir_q ? P_BIT_LOW : P_WAIT_BYTE;
							end else begin
								left_d = left_dec;
								if (left_dec == '0) begin
									if (stopw_q) begin err_d = ST_OK; phase_d = P_STOP_LOW; end
									else begin phase_d = P_IDLE; done = 1'b1; end
								end else phase_d = P_WAIT_BYTE;
							end
						end
					end
				end
			end
			P_WAIT_BYTE: begin
				sda_d = 1'b0;
				if (tick.mode == MODE_WBYTE) begin
					shb_d = tick.write_byte; bitc_d = '0; dcnt_d = '0; phase_d = P_BIT_LOW;
				end else begin
					wcnt_d = winc;
					if (tmo) begin
						err_d = ST_TMO; scl_d = 1'b1; dcnt_d = '0; phase_d = P_STOP_LOW;
					end
				end
			end
			P_STOP_LOW: begin
				scl_d = 1'b1;
				if (dcnt_q == '0) sda_d = 1'b1;
				dcnt_d = lo_hit ? '0 : dinc;
				if (lo_hit) begin scl_d = 1'b0; wcnt_d = '0; phase_d = P_STOP_RISE; end
			end
			P_RS_RISE, P_BIT_RISE, P_STOP_RISE: begin
				if (tick.scl_in) begin
					dcnt_d = '0;
					if (phase_q == P_RS_RISE) phase_d = P_START_SETUP;
					else if (phase_q == P_STOP_RISE) phase_d = P_STOP_HIGH;
					else if (sda_q && tick.sda_in) begin
						err_d = ST_BUS; scl_d = 1'b1; phase_d = P_STOP_LOW;
					end else if (!recv && bitc_q < 4'd8 && !sda_q && !tick.sda_in) begin
						scl_d = 1'b0; sda_d = 1'b0; own_d = 1'b0;
						phase_d = P_IDLE; done = 1'b1; st = ST_ARB;
					end else begin
						seen_d = tick.sda_in;
						if (recv && bitc_q < 4'd8) shb_d = {shb_q[6:0], tick.sda_in};
						phase_d = P_BIT_HIGH;
					end
				end else begin
					wcnt_d = winc;
					if (tmo) begin
						if (phase_q == P_STOP_RISE) begin
							scl_d = 1'b0; sda_d = 1'b0; own_d = 1'b0;
							phase_d = P_IDLE; done = 1'b1;
							st = (err_q != ST_OK) ? err_q : ST_TMO;
						end else begin
							err_d = ST_TMO; scl_d = 1'b1; dcnt_d = '0; phase_d = P_STOP_LOW;
						end
					end
				end
			end
			P_STOP_HIGH: begin
				dcnt_d = hi_hit ? '0 : dinc;
				if (hi_hit) begin sda_d = 1'b0; phase_d = P_STOP_FREE; end
			end
			P_STOP_FREE: begin
				dcnt_d = hi_hit ? '0 : dinc;
				if (hi_hit) begin own_d = 1'b0; phase_d = P_IDLE; done = 1'b1; st = err_q; end
			end
			default: phase_d = P_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_IDLE; bitc_q <= '0; shb_q <= '0; left_q <= '0;
			dcnt_q <= '0; wcnt_q <= '0; dir_q <= 1'b0; stopw_q <= 1'b0;
			own_q <= 1'b0; astep_q <= '0; seen_q <= 1'b0; err_q <= ST_OK;
			scl_q <= 1'b0; sda_q <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d; bitc_q <= bitc_d; shb_q <= shb_d; left_q <= left_d;
			dcnt_q <= dcnt_d; wcnt_q <= wcnt_d; dir_q <= dir_d; stopw_q <= stopw_d;
			own_q <= own_d; astep_q <= astep_d; seen_q <= seen_d; err_q <= err_d;
			scl_q <= scl_d; sda_q <= sda_d;
		end
	end

	always_comb begin
		res.scl_low         = scl_d;
		res.sda_low         = sda_d;
		res.read_byte       = rb;
		res.read_valid      = rv;
		res.need_write_byte = phase_d == P_WAIT_BYTE;
		res.message_done    = done;
		res.status          = st;
		res.busy_res        = phase_d != P_IDLE;
	end

	ap_status_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		step && !done |-> st == ST_OK) else $error("status without done");
	ap_rv_recv: assert property (@(posedge clk) disable iff (!arst_n)
		step && rv |-> phase_q == P_BIT_HIGH) else $error("read_valid outside bit high");
	ap_wait_own: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == P_WAIT_BYTE |-> own_q) else $error("waiting for byte without bus");
endmodule

@@ sv/i2cm_out_skid.sv @@
// ---------------------------------------------------------------------------
// i2cm_out_skid
// two-entry output buffer so input can advance while a result waits
// ---------------------------------------------------------------------------
module i2cm_out_skid (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  i2cm_pkg::res_t in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output i2cm_pkg::res_t out_data
);
	import i2cm_pkg::*;

	res_t main_q, skid_q;
	logic main_v_q, skid_v_q;

	assign in_ready  = !skid_v_q;
	assign out_valid = main_v_q;
	assign out_data  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (!main_v_q || out_ready) begin
				main_v_q <= skid_v_q || in_valid;
				skid_v_q <= 1'b0;
			end else if (in_valid && in_ready) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!main_v_q || out_ready) main_q <= skid_v_q ? skid_q : in_data;
		if (in_valid && in_ready) skid_q <= in_data;
	end
endmodule

@@ sv/i2c_master_transfer_engine.sv @@
// a tick's result passes a result register and then the output buffer before it is offered on m_tdata
// throughput: one tick per cycle while the output buffer has room; the state update is a single registered pass
// a two-entry output buffer keeps input flowing while a result waits
// reset: arst_n clears to idle, bus released, divider 80, other control and state registers 0
// ---------------------------------------------------------------------------
// i2c_master_transfer_engine
// i2c bus master, one message at a time, one sampled bus tick per item
// ---------------------------------------------------------------------------
module i2c_master_transfer_engine #(
	parameter int LENGTH_BITS  = i2cm_pkg::LENGTH_BITS_DEF,
	parameter int DIVIDER_BITS = i2cm_pkg::DIVIDER_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	// mode, msg_read, msg_start, msg_stop, msg_length, write_byte, sda_in, scl_in
	input  logic [31:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// scl_low, sda_low, read_byte, read_valid, need_write_byte, message_done,
	// status, busy_res
	output logic [23:0] m_tdata
);
	import i2cm_pkg::*;

	logic [DIVIDER_BITS-1:0] divider;
	cfg_t  cfg;
	tick_t tick;
	res_t  res, ores;
	logic  step, res_v_q;

	assign tick.mode       = s_tdata[1:0];
	assign tick.msg_read   = s_tdata[2];
	assign tick.msg_start  = s_tdata[3];
	assign tick.msg_stop   = s_tdata[4];
	assign tick.msg_length = s_tdata[20:5];
	assign tick.write_byte = s_tdata[28:21];
	assign tick.sda_in     = s_tdata[29];
	assign tick.scl_in     = s_tdata[30];

	logic buf_ready;
	res_t res_q;
	assign s_tready = buf_ready;
	assign step     = s_tvalid && s_tready;

	i2cm_cfg_regs #(.DIVIDER_BITS(DIVIDER_BITS)) u_cfg (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data, .divider, .cfg
	);

	i2cm_engine #(.LENGTH_BITS(LENGTH_BITS), .DIVIDER_BITS(DIVIDER_BITS)) u_eng (
		.clk, .arst_n, .step, .tick, .divider, .cfg, .res
	);

	// result register after the state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) res_v_q <= 1'b0;
		else if (buf_ready) res_v_q <= step;
	end
	always_ff @(posedge clk) begin
		if (step) res_q <= res;
	end

	i2cm_out_skid u_skid (
		.clk, .arst_n, .in_valid(res_v_q), .in_ready(buf_ready), .in_data(res_q),
		.out_valid(m_tvalid), .out_ready(m_tready), .out_data(ores)
	);

	assign m_tdata = {7'd0, ores.busy_res, ores.status, ores.message_done,
		ores.need_write_byte, ores.read_valid, ores.read_byte, ores.sda_low, ores.scl_low};
endmodule

@@ sim/i2c_master_transfer_engine_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// i2c_master_transfer_engine_tb
// ticks carry sampled bus levels from a simple target model that answers the
// engine's own drive; every tick's line drive and status is predicted here and
// compared in order, with random gaps on the input side and stalls on the output
// ---------------------------------------------------------------------------
module i2c_master_transfer_engine_tb;
	import i2cm_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;

	i2c_master_transfer_engine DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.s_tdata(s_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	// engine copy: registers
	int unsigned   c_div, c_fast, c_addr, c_ten, c_tmo;
	// engine copy: state
	logic [3:0]    ph;
	int unsigned   bcnt, dcnt, wcnt, astep;
	logic [7:0]    shb;
	logic [15:0]   left;
	logic          dir_rd, stop_w, owned, sda_seen, scl_d, sda_d;
	logic [2:0]    err_st;
	logic [7:0]    o_rb;
	logic          o_rv, o_done;
	logic [2:0]    o_st;

	logic [31:0]   tick_q[$];
	logic [16:0]   line_q[$];
	int            errors = 0;
	int            ticks_sent = 0;
	int            msgs_sent = 0;
	int            seen = 0;

	// target model knobs
	int            stretch_pct = 2;
	int            noise_pct = 2;
	int            nack_pct = 10;
	bit            hold_bytes = 0;
	bit            force_nack = 0;
	logic          bus_sda = 1;
	bit            gaps_on = 1;

	function automatic int unsigned hi_t();
		return (c_div == 0) ? 1 : c_div;
	endfunction

	function automatic int unsigned lo_t();
		int unsigned l;
		l = c_fast ? 2 * hi_t() : hi_t();
		return (l < 2) ? 2 : l;
	endfunction

	function automatic bit count_to(int unsigned n);
		dcnt++;
		if (dcnt >= n) begin
			dcnt = 0;
			return 1;
		end
		return 0;
	endfunction

	function automatic bit wait_expired();
		if (wcnt < 16'hFFFF) wcnt++;
		return c_tmo != 0 && wcnt >= c_tmo;
	endfunction

	function automatic void end_msg(logic [2:0] st);
		ph = P_IDLE;
		o_done = 1;
		o_st = st;
	endfunction

	function automatic void force_stop(logic [2:0] st);
		err_st = st;
		scl_d = 1;
		dcnt = 0;
		ph = P_STOP_LOW;
	endfunction

	function automatic void give_up_bus();
		scl_d = 0;
		sda_d = 0;
		owned = 0;
		end_msg(ST_ARB);
	endfunction

	function automatic void close_ok();
		if (stop_w) force_stop(ST_OK);
		else end_msg(ST_OK);
	endfunction

	function automatic void to_data();
		astep = 0;
		bcnt = 0;
		dcnt = 0;
		wcnt = 0;
		ph = dir_rd ? P_BIT_LOW : P_WAIT_BYTE;
	endfunction

	function automatic logic [7:0] hdr();
		return HDR_BASE | {5'd0, c_addr[9:8], 1'b0};
	endfunction

	// one tick of the engine; fields packed as on s_tdata
	function automatic logic [16:0] bus_step(logic [31:0] t);
		logic [1:0]  md;
		logic        sdi, scli, rcv;
		logic [15:0] len;
		md   = t[1:0];
		len  = t[20:5];
		sdi  = t[29];
		scli = t[30];
		rcv  = astep == 0 && dir_rd;
		o_rb = 0; o_rv = 0; o_done = 0; o_st = ST_OK;
		case (ph)
		P_IDLE: begin
			if (owned) sda_d = 0;
			if (md == MODE_MSG) begin
				if (len == 0) end_msg(ST_BUS);
				else begin
					dir_rd = t[2];
					stop_w = t[4];
					left = len;
					err_st = ST_OK;
					dcnt = 0;
					wcnt = 0;
					if (t[3]) begin
						astep = 0;
						ph = owned ? P_RS_LOW : P_BUSFREE;
					end else if (!owned) end_msg(ST_BUS);
					else to_data();
				end
			end
		end
		P_BUSFREE: begin
			if (scli && sdi) begin
				dcnt = 0;
				ph = P_START_SETUP;
			end else if (wait_expired()) end_msg(ST_TMO);
		end
		P_RS_LOW: begin
			scl_d = 1;
			sda_d = 0;
			if (count_to(lo_t())) begin
				scl_d = 0; wcnt = 0; ph = P_RS_RISE;
			end
		end
		P_RS_RISE: begin
			if (scli) begin
				dcnt = 0;
				ph = P_START_SETUP;
			end else if (wait_expired()) force_stop(ST_TMO);
		end
		P_START_SETUP: begin
			if (!sdi) give_up_bus();
			else if (count_to(hi_t())) begin
				sda_d = 1;
				ph = P_START_HOLD;
			end
		end
		P_START_HOLD: begin
			if (count_to(hi_t())) begin
				scl_d = 1;
				owned = 1;
				if (astep == 2) begin
					astep = 3;
					shb = hdr() | 8'h01;
				end else begin
					astep = 1;
					shb = c_ten ? hdr() : {c_addr[6:0], dir_rd};
				end
				bcnt = 0;
				ph = P_BIT_LOW;
			end
		end
		P_BIT_LOW: begin
			if (dcnt == 0) begin
				if (bcnt < 8) sda_d = rcv ? 1'b0 : ~shb[7 - bcnt];
				else sda_d = rcv && left > 1;
			end
			if (count_to(lo_t())) begin
				scl_d = 0; wcnt = 0; ph = P_BIT_RISE;
			end
		end
		P_BIT_RISE: begin
			if (scli) begin
				if (sda_d && sdi) force_stop(ST_BUS);
				else if (!rcv && bcnt < 8 && !sda_d && !sdi) give_up_bus();
				else begin
					sda_seen = sdi;
					if (rcv && bcnt < 8) shb = {shb[6:0], sdi};
					dcnt = 0;
					ph = P_BIT_HIGH;
				end
			end else if (wait_expired()) force_stop(ST_TMO);
		end
		P_BIT_HIGH: begin
			if (sdi != sda_seen) force_stop(ST_BUS);
			else if (count_to(hi_t())) begin
				scl_d = 1;
				if (bcnt < 8) begin
					if (rcv && bcnt == 7) begin
						o_rb = shb; o_rv = 1;
					end
					bcnt++;
					ph = P_BIT_LOW;
				end else begin
					bcnt = 0; dcnt = 0; wcnt = 0;
					if (rcv) begin
						if (left > 0) left--;
						if (left == 0) close_ok(); else ph = P_BIT_LOW;
					end else if (sda_seen) force_stop(ST_NACK);
					else if (astep == 1) begin
						if (c_ten) begin
							shb = c_addr[7:0]; astep = 2; ph = P_BIT_LOW;
						end else to_data();
					end else if (astep == 2) begin
						if (dir_rd) ph = P_RS_LOW; else to_data();
					end else if (astep == 3) to_data();
					else begin
						if (left > 0) left--;
						if (left == 0) close_ok(); else ph = P_WAIT_BYTE;
					end
				end
			end
		end
		P_WAIT_BYTE: begin
			sda_d = 0;
			if (md == MODE_WBYTE) begin
				shb = t[28:21];
				bcnt = 0;
				dcnt = 0;
				ph = P_BIT_LOW;
			end else if (wait_expired()) force_stop(ST_TMO);
		end
		P_STOP_LOW: begin
			scl_d = 1;
			if (dcnt == 0) sda_d = 1;
			if (count_to(lo_t())) begin
				scl_d = 0; wcnt = 0; ph = P_STOP_RISE;
			end
		end
		P_STOP_RISE: begin
			if (scli) begin
				dcnt = 0;
				ph = P_STOP_HIGH;
			end else if (wait_expired()) begin
				scl_d = 0; sda_d = 0; owned = 0;
				end_msg(err_st != ST_OK ? err_st : ST_TMO);
			end
		end
		P_STOP_HIGH: begin
			if (count_to(hi_t())) begin
				sda_d = 0;
				ph = P_STOP_FREE;
			end
		end
		P_STOP_FREE: begin
			if (count_to(hi_t())) begin
				owned = 0;
				end_msg(err_st);
			end
		end
		default: ph = P_IDLE;
		endcase
		return {ph != P_IDLE, o_st, o_done, ph == P_WAIT_BYTE, o_rv, o_rb, sda_d, scl_d};
	endfunction

	// build one tick with bus levels from the target model, predict and queue it
	task automatic send_tick(logic [1:0] md, logic rd, logic st, logic sp,
			logic [15:0] len, logic [7:0] wb);
		logic        scli, sdi, rcv;
		logic [31:0] t;
		rcv = astep == 0 && dir_rd;
		if (scl_d) begin
			// target changes sda only while the clock is held low
			if (ph == P_BIT_LOW && rcv && bcnt < 8) bus_sda = 1'($urandom_range(0, 1));
			else if (ph == P_BIT_LOW && !rcv && bcnt == 8)
				bus_sda = force_nack || ($urandom_range(0, 99) < nack_pct);
			else bus_sda = 1;
		end
		scli = scl_d ? 1'b0 : ($urandom_range(0, 99) >= stretch_pct);
		sdi  = sda_d ? 1'b0 : bus_sda;
		if ($urandom_range(0, 99) < noise_pct) sdi = ~sdi;
		if ($urandom_range(0, 199) < noise_pct) scli = ~scli;
		t = {1'b0, scli, sdi, wb, len, sp, st, rd, md};
		line_q.push_back(bus_step(t));
		tick_q.push_back(t);
		ticks_sent++;
	endtask

	task automatic plain_tick();
		logic [1:0] md;
		int         r;
		r = $urandom_range(0, 99);
		md = (r < 85) ? MODE_TICK : (r < 90) ? 2'd3 : (r < 95) ? MODE_MSG : MODE_WBYTE;
		if (ph == P_WAIT_BYTE && md == MODE_WBYTE && hold_bytes) md = MODE_TICK;
		send_tick(md, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)), 16'($urandom_range(0, 16'hFFFF)),
			8'($urandom_range(0, 255)));
	endtask

	// issue a message command and tick until the engine is idle again
	task automatic run_msg(logic rd, logic st, logic sp, logic [15:0] len);
		int guard;
		guard = 0;
		send_tick(MODE_MSG, rd, st, sp, len, 8'($urandom_range(0, 255)));
		msgs_sent++;
		while (ph != P_IDLE && guard < 200000) begin
			if (ph == P_WAIT_BYTE && !hold_bytes && $urandom_range(0, 9) < 7)
				send_tick(MODE_WBYTE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), 16'($urandom_range(0, 16'hFFFF)),
					8'($urandom_range(0, 255)));
			else plain_tick();
			guard++;
		end
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		@(posedge clk);
		cfg_we    <= 1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 0;
		case (idx)
		CFG_DIV:  c_div  = val[11:0];
		CFG_FAST: c_fast = val[0];
		CFG_ADDR: c_addr = val[9:0];
		CFG_TEN:  c_ten  = val[0];
		default:  c_tmo  = val;
		endcase
	endtask

	task automatic set_regs(int unsigned dv, fs, ad, tn, tm);
		// let all queued ticks drain and the output buffer settle first
		while (tick_q.size() != 0 || line_q.size() != 0 || s_tvalid) @(posedge clk);
		repeat (8) @(posedge clk);
		write_reg(CFG_DIV, 16'(dv));
		write_reg(CFG_FAST, 16'(fs));
		write_reg(CFG_ADDR, 16'(ad));
		write_reg(CFG_TEN, 16'(tn));
		write_reg(CFG_TMO, 16'(tm));
	endtask

	task automatic random_msgs(int n_ticks);
		int stop_at;
		stop_at = ticks_sent + n_ticks;
		while (ticks_sent < stop_at) begin
			if ($urandom_range(0, 4) == 0) plain_tick();
			else run_msg(1'($urandom_range(0, 1)),
				owned ? ($urandom_range(0, 2) != 0) : 1'b1,
				$urandom_range(0, 9) < 7,
				($urandom_range(0, 19) == 0) ? 16'd0 : 16'($urandom_range(1, 3)));
		end
		// a message started by a stray command runs out before settings change
		while (ph != P_IDLE) plain_tick();
	endtask

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("timeout at %0t", $time);
		$display("Some tests failed");
		$finish;
	end

	// input driver
	int in_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 0;
			s_tdata  <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				void'(tick_q.pop_front());
				in_gap = gaps_on ? $urandom_range(0, 13) : 0;
			end else if (!s_tvalid && in_gap > 0) in_gap--;
			if (in_gap == 0 && tick_q.size() > 0) begin
				s_tvalid <= 1;
				s_tdata  <= tick_q[0];
			end else s_tvalid <= 0;
		end
	end

	// output monitor
	int out_stall = 0;
	always @(posedge clk or negedge arst_n) begin
		logic [16:0] want;
		if (!arst_n) m_tready <= 0;
		else begin
			if (m_tvalid && m_tready) begin
				seen++;
				if (line_q.size() == 0) begin
					$display("%0t: unexpected transfer %h", $time, m_tdata);
					errors++;
				end else begin
					want = line_q.pop_front();
					if (m_tdata !== {7'd0, want}) begin
						$display("%0t: mismatch expected %h actual %h", $time,
							{7'd0, want}, m_tdata);
						errors++;
					end
				end
				out_stall = gaps_on ? $urandom_range(0, 13) : 0;
			end else if (out_stall > 0) out_stall--;
			m_tready <= (out_stall == 0);
		end
	end

	initial begin
		int guard;
		arst_n = 0; cfg_we = 0; cfg_index = 0; cfg_data = 0;
		c_div = 80; c_fast = 0; c_addr = 0; c_ten = 0; c_tmo = 0;
		ph = P_IDLE; bcnt = 0; dcnt = 0; wcnt = 0; astep = 0; shb = 0; left = 0;
		dir_rd = 0; stop_w = 0; owned = 0; sda_seen = 0; scl_d = 0; sda_d = 0; err_st = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;

		// directed: 7-bit, fastest clock, clean bus
		set_regs(1, 0, 0, 0, 0);
		noise_pct = 0; stretch_pct = 0; nack_pct = 0;
		run_msg(1'b0, 1'b1, 1'b1, 16'd0);       // zero length
		run_msg(1'b0, 1'b0, 1'b1, 16'd1);       // no start on a free bus
		run_msg(1'b0, 1'b1, 1'b0, 16'd1);       // keep the bus
		run_msg(1'b0, 1'b0, 1'b0, 16'd1);       // continue without start
		run_msg(1'b1, 1'b1, 1'b1, 16'd2);       // repeated start, ack then nack
		force_nack = 1;
		run_msg(1'b0, 1'b1, 1'b1, 16'hFFFF);    // address nack ends it
		force_nack = 0;

		// 10-bit read and write, timeouts
		set_regs(1, 1, 10'h3FF, 1, 10);
		run_msg(1'b1, 1'b1, 1'b1, 16'd1);
		hold_bytes = 1;
		run_msg(1'b0, 1'b1, 1'b1, 16'd1);       // write-byte wait runs out
		hold_bytes = 0;
		stretch_pct = 100;
		run_msg(1'b0, 1'b1, 1'b1, 16'd1);       // bus never free

		// fast mode, back to back ticks and results
		set_regs(2, 1, 10'h2AA, 0, 16'hFFFF);
		stretch_pct = 3; noise_pct = 2; nack_pct = 10;
		gaps_on = 0;
		random_msgs(30);
		gaps_on = 1;

		// 10-bit with short timeouts and a noisy bus
		set_regs(1, 0, 10'h155, 1, 3);
		stretch_pct = 40; noise_pct = 4;
		random_msgs(30);

		// slowest clock: only messages that end at once
		set_regs(4095, 1, 0, 0, 1);
		repeat (6) run_msg(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b1, 16'd0);
		if (!owned) run_msg(1'b0, 1'b0, 1'b0, 16'd5);

		guard = 0;
		while ((tick_q.size() != 0 || line_q.size() != 0) && guard < 500000) begin
			@(posedge clk);
			guard++;
		end
		repeat (20) @(posedge clk);
		$display("%0d ticks in %0d messages checked, %0d results compared", ticks_sent,
			msgs_sent, seen);
		$display("covered 7/10-bit addressing, reads, writes, timeouts, nacks, line noise");
		if (errors == 0 && line_q.size() == 0) $display("All tests passed");
		else $display("Some tests failed");
		$finish;
	end

endmodule
